// File: hdl/nparb_pkg.sv
// Shared types and constants for the neighbour-pair FIFO arbiter.
package nparb_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int ID_W        = 4;
  localparam int CFG_W       = 5;
  localparam int QA_W        = $clog2(MAX_CLIENTS);
  localparam int QC_W        = $clog2(MAX_CLIENTS + 1);

  localparam logic CMD_REQ = 1'b0;
  localparam logic CMD_REL = 1'b1;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_NONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_TEST
  } back_state_t;

  // Classified event handed from front to back.
  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] id;
    logic            range_err;
  } event_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] granted_id;
    kind_t           kind;
    logic            last;
  } result_t;

endpackage

// File: hdl/fifo_neighbor_pair_arbiter_top.sv
// Top level of the neighbour-pair FIFO arbiter.
//
// Clients sit on a ring of client_count positions and each needs both
// resources it shares with its ring neighbours. A request (cmd 0) joins a
// strict FIFO wait queue; a release (cmd 1) marks the client idle. After
// each event the queue head is granted for as long as both its neighbours
// are idle, one result transfer per grant, or one 'none' result when
// nothing is granted; protocol errors give one error result and change
// nothing. A command transfer happens on a rising edge with start high and
// busy low; one command is worked on at a time. Results appear on
// granted_id/kind/last for exactly one cycle, marked by valid, and the
// receiver cannot stall them. After a transfer busy is high while the
// event is in the event queue and, unless it is an error, also through
// ST_WAIT and ST_TEST of each grant test, each test waiting in ST_WAIT for
// the wait-queue RAM's registered read of the new head. Grant results
// come out one drain step behind their test; the final result (last = 1)
// is on the ports in the first cycle that busy is low again, so the next
// command may transfer at the edge that takes it. Writing client_count
// (clamped to 1..16) also returns all client state to its reset values;
// write it only while busy is low.
module fifo_neighbor_pair_arbiter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [nparb_pkg::ID_W-1:0]  client_id,
  input  logic                        cfg_we,
  input  logic [nparb_pkg::CFG_W-1:0] cfg_wdata,
  output logic                        valid,
  output logic [nparb_pkg::ID_W-1:0]  granted_id,
  output nparb_pkg::kind_t            kind,
  output logic                        last
);

  import nparb_pkg::*;

  logic             push;
  event_t           front_ev;
  event_t           head_ev;
  logic             ev_valid;
  logic             pop;
  logic             back_active;
  logic [CFG_W-1:0] client_count;
  result_t          res;

  // Front: hold the ring size, take commands and flag ids out of range.
  nparb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .client_id   (client_id),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .client_count(client_count),
    .push        (push),
    .ev          (front_ev)
  );

  // Decouple intake from execution.
  nparb_evq u_evq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_ev(front_ev),
    .pop    (pop),
    .valid  (ev_valid),
    .head_ev(head_ev)
  );

  // Back: apply the event, then drain grants from the wait queue.
  nparb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .clr         (cfg_we),
    .client_count(client_count),
    .ev_valid    (ev_valid),
    .ev          (head_ev),
    .pop         (pop),
    .active      (back_active),
    .res         (res)
  );

  // Hold off new commands while one is queued or being drained.
  assign busy       = ev_valid || back_active;

  assign valid      = res.valid;
  assign granted_id = res.granted_id;
  assign kind       = res.kind;
  assign last       = res.last;

endmodule

// File: hdl/nparb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nparb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/nparb_front.sv
// Front end: ring size register, command intake and range classification.
module nparb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          cmd,
  input  logic [nparb_pkg::ID_W-1:0]    client_id,
  input  logic                          cfg_we,
  input  logic [nparb_pkg::CFG_W-1:0]   cfg_wdata,
  output logic [nparb_pkg::CFG_W-1:0]   client_count,
  output logic                          push,
  output nparb_pkg::event_t             ev
);

  import nparb_pkg::*;

  logic [CFG_W-1:0] count_clamped;

  // clamp the ring size into 1..MAX_CLIENTS
  always_comb begin
    if (cfg_wdata == '0) begin
      count_clamped = CFG_W'(1);
    end else if (int'(cfg_wdata) > MAX_CLIENTS) begin
      count_clamped = CFG_W'(MAX_CLIENTS);
    end else begin
      count_clamped = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      client_count <= CFG_W'(MAX_CLIENTS);
    end else if (cfg_we) begin
      client_count <= count_clamped;
    end
  end

  assign push         = start && !busy;
  assign ev.cmd       = cmd;
  assign ev.id        = client_id;
  assign ev.range_err = (CFG_W'(client_id) >= client_count);

endmodule

// File: hdl/nparb_evq.sv
// Two-entry event queue between front and back.
module nparb_evq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  nparb_pkg::event_t push_ev,
  input  logic              pop,
  output logic              valid,
  output nparb_pkg::event_t head_ev
);

  import nparb_pkg::*;

  event_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (push && fill != 2'd2) begin
      slot[wr_ptr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && fill != 2'd2) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && valid) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'((push && fill != 2'd2) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
    end
  end

  assign valid   = (fill != 2'd0);
  assign head_ev = slot[rd_ptr];

endmodule

// File: hdl/nparb_back.sv
// Back end: client state, wait queue and grant drain sequencer.
module nparb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr,
  input  logic [nparb_pkg::CFG_W-1:0] client_count,
  input  logic                        ev_valid,
  input  nparb_pkg::event_t           ev,
  output logic                        pop,
  output logic                        active,
  output nparb_pkg::result_t          res
);

  import nparb_pkg::*;

  back_state_t            state, state_next;
  logic [MAX_CLIENTS-1:0] idle_mask, idle_mask_next;
  logic [MAX_CLIENTS-1:0] waiting_mask, waiting_mask_next;
  logic [QA_W-1:0]        queue_head, queue_head_next;
  logic [QA_W-1:0]        queue_tail, queue_tail_next;
  logic [QC_W-1:0]        queue_count, queue_count_next;
  logic                   pend_valid, pend_valid_next;
  logic [ID_W-1:0]        pend_id, pend_id_next;
  result_t                res_next;

  logic                   ram_we;
  logic [ID_W-1:0]        head_id;
  logic [CFG_W-1:0]       h_plus1;
  logic [CFG_W-1:0]       n_minus1;
  logic [ID_W-1:0]        right_id;
  logic [ID_W-1:0]        left_id;
  logic                   grant;

  nparb_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_CLIENTS)
  ) u_queue_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(queue_tail),
    .wdata(ev.id),
    .raddr(queue_head),
    .rdata(head_id)
  );

  // ring neighbours of the queue head
  assign h_plus1  = CFG_W'(head_id) + CFG_W'(1);
  assign n_minus1 = client_count - CFG_W'(1);
  assign right_id = (h_plus1 == client_count) ? '0 : h_plus1[ID_W-1:0];
  assign left_id  = (head_id == '0) ? n_minus1[ID_W-1:0] : head_id - ID_W'(1);
  assign grant    = (queue_count != '0) && idle_mask[right_id] && idle_mask[left_id];

  always_comb begin
    state_next        = state;
    idle_mask_next    = idle_mask;
    waiting_mask_next = waiting_mask;
    queue_head_next   = queue_head;
    queue_tail_next   = queue_tail;
    queue_count_next  = queue_count;
    pend_valid_next   = pend_valid;
    pend_id_next      = pend_id;
    res_next          = '{valid: 1'b0, granted_id: '0, kind: KIND_NONE, last: 1'b0};
    ram_we            = 1'b0;
    pop               = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (ev_valid) begin
          pop = 1'b1;
          if (ev.range_err) begin
            res_next = '{valid: 1'b1, granted_id: '0, kind: KIND_ERROR, last: 1'b1};
          end else if (ev.cmd == CMD_REQ) begin
            if (!idle_mask[ev.id] || waiting_mask[ev.id] ||
                int'(queue_count) >= MAX_CLIENTS) begin
              res_next = '{valid: 1'b1, granted_id: '0, kind: KIND_ERROR, last: 1'b1};
            end else begin
              ram_we                   = 1'b1;
              queue_tail_next          = (queue_tail == QA_W'(MAX_CLIENTS - 1)) ? '0 :
                                         queue_tail + QA_W'(1);
              queue_count_next         = queue_count + QC_W'(1);
              waiting_mask_next[ev.id] = 1'b1;
              state_next               = ST_WAIT;
            end
          end else begin
            if (idle_mask[ev.id]) begin
              res_next = '{valid: 1'b1, granted_id: '0, kind: KIND_ERROR, last: 1'b1};
            end else begin
              idle_mask_next[ev.id] = 1'b1;
              state_next            = ST_WAIT;
            end
          end
        end
      end
      ST_WAIT: begin
        // let the head entry settle through the RAM read register
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (grant) begin
          queue_head_next            = (queue_head == QA_W'(MAX_CLIENTS - 1)) ? '0 :
                                       queue_head + QA_W'(1);
          queue_count_next           = queue_count - QC_W'(1);
          waiting_mask_next[head_id] = 1'b0;
          idle_mask_next[head_id]    = 1'b0;
          if (pend_valid) begin
            res_next = '{valid: 1'b1, granted_id: pend_id, kind: KIND_GRANT, last: 1'b0};
          end
          pend_valid_next = 1'b1;
          pend_id_next    = head_id;
          state_next      = ST_WAIT;
        end else begin
          if (pend_valid) begin
            res_next = '{valid: 1'b1, granted_id: pend_id, kind: KIND_GRANT, last: 1'b1};
          end else begin
            res_next = '{valid: 1'b1, granted_id: '0, kind: KIND_NONE, last: 1'b1};
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      state        <= ST_IDLE;
      idle_mask    <= '1;
      waiting_mask <= '0;
      queue_head   <= '0;
      queue_tail   <= '0;
      queue_count  <= '0;
      pend_valid   <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      state        <= state_next;
      idle_mask    <= idle_mask_next;
      waiting_mask <= waiting_mask_next;
      queue_head   <= queue_head_next;
      queue_tail   <= queue_tail_next;
      queue_count  <= queue_count_next;
      pend_valid   <= pend_valid_next;
      res.valid    <= res_next.valid;
    end
    pend_id        <= pend_id_next;
    res.granted_id <= res_next.granted_id;
    res.kind       <= res_next.kind;
    res.last       <= res_next.last;
  end

  assign active = (state != ST_IDLE);

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == KIND_ERROR |-> res.last)
    else $error("error result without last");

  a_wait_then_test: assert property (@(posedge clk) disable iff (rst)
    !clr && state == ST_WAIT |=> state == ST_TEST)
    else $error("wait state did not advance to test");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(queue_count) <= MAX_CLIENTS)
    else $error("wait queue overfilled");

  a_waiting_idle: assert property (@(posedge clk) disable iff (rst)
    (waiting_mask & ~idle_mask) == '0)
    else $error("queued client marked busy");

  a_pend_only_draining: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("pending grant left over in idle");

endmodule
